>>> rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, register codes, reset values and saturating helpers for the
// mass-spring chain step unit.
// ----------------------------------------------------------------------------
package msc_pkg;

	localparam int NODES_DEF = 16;
	localparam int FRAC_DEF  = 24;
	localparam int REG_W     = 31;

	typedef enum logic [2:0] {
		REG_STIFF  = 3'd0,
		REG_DAMP   = 3'd1,
		REG_INVM   = 3'd2,
		REG_WEIGHT = 3'd3,
		REG_DT     = 3'd4,
		REG_REST   = 3'd5,
		REG_NODES  = 3'd6
	} reg_idx_t;

	localparam logic [30:0] RST_STIFF  = 31'd838860800;
	localparam logic [30:0] RST_DAMP   = 31'd1677722;
	localparam logic [30:0] RST_INVM   = 31'd335544320;
	localparam logic [30:0] RST_WEIGHT = 31'd8229225;
	localparam logic [24:0] RST_DT     = 25'd8389;
	localparam logic [30:0] RST_REST   = 31'd838861;
	localparam logic [4:0]  RST_NODES  = 5'd10;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
	} node_t;

	typedef struct packed {
		logic shift;
		logic f_we;
	} cell_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [31:0] sat_mag(input logic [63:0] m, input logic neg);
		logic big;
		big = |m[63:31];
		if (neg)
			return big ? 32'sh8000_0000 : -$signed(m[31:0]);
		else
			return big ? 32'sh7fff_ffff : $signed(m[31:0]);
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
			return v[31:0];
		else if (v[33])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

	function automatic logic [31:0] mag32(input logic signed [32:0] v);
		logic [32:0] a;
		a = v[32] ? 33'(-v) : 33'(v);
		return a[31:0];
	endfunction

	function automatic logic signed [31:0] rst_pos_x(input int j);
		logic [63:0] p;
		p = 64'(RST_REST) * 64'(j);
		return sat_mag(p, 1'b0);
	endfunction

endpackage

>>> rtl/msc_cell.sv
// ----------------------------------------------------------------------------
// msc_cell
// One node of the chain ring: position, velocity and force accumulator.
// Takes its neighbor's record on shift; force can be overwritten in place.
// ----------------------------------------------------------------------------
module msc_cell #(
	parameter logic signed [31:0] PX_RST = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  msc_pkg::cell_ctl_t    ctl,
	input  msc_pkg::node_t        d_in,
	input  logic signed [31:0]    fx_in,
	input  logic signed [31:0]    fy_in,
	output msc_pkg::node_t        q
);
	import msc_pkg::*;

	node_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q    <= '0;
			rec_q.px <= PX_RST;
		end else if (ctl.shift) begin
			rec_q <= d_in;
		end else if (ctl.f_we) begin
			rec_q.fx <= fx_in;
			rec_q.fy <= fy_in;
		end
	end

	assign q = rec_q;

endmodule

>>> rtl/msc_sqrt.sv
// ----------------------------------------------------------------------------
// msc_sqrt
// Floor square root of a 63-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module msc_sqrt (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [62:0]          rad,
	output msc_pkg::unit_stat_t  stat,
	output logic [31:0]          root
);
	import msc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rad_q;
	logic [35:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rem_n;
	logic [35:0] trial;

	assign rem_n = {rem_q[33:0], rad_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rad_q  <= {1'b0, rad};
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rad_q <= {rad_q[61:0], 2'b00};
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

>>> rtl/msc_div.sv
// ----------------------------------------------------------------------------
// msc_div
// Unsigned 64 by 33 bit divide, one quotient bit per cycle. Quotients of
// 2^32 or more come back as all ones.
// ----------------------------------------------------------------------------
module msc_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [63:0]          dividend,
	input  logic [32:0]          divisor,
	output msc_pkg::unit_stat_t  stat,
	output logic [63:0]          quo
);
	import msc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic        ovf_q;
	logic [4:0]  cnt_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] q_q;
	logic [33:0] rem_n;
	logic [33:0] sub;

	assign rem_n = {rem_q, lo_q[31]};
	assign sub   = rem_n - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			lo_q   <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q <= divisor;
				rem_q <= {1'b0, dividend[63:32]};
				lo_q  <= dividend[31:0];
				cnt_q <= '0;
				if ({1'b0, dividend[63:32]} >= divisor) begin
					ovf_q  <= 1'b1;
					done_q <= 1'b1;
				end else begin
					ovf_q  <= 1'b0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				lo_q <= {lo_q[30:0], 1'b0};
				if (!sub[33]) begin
					rem_q <= sub[32:0];
					q_q   <= {q_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_n[32:0];
					q_q   <= {q_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = ovf_q ? '1 : {32'd0, q_q};

endmodule

>>> rtl/mass_spring_chain_step_unit.sv
// ----------------------------------------------------------------------------
// mass_spring_chain_step_unit
// One semi-implicit Euler step of a planar mass-spring chain per input beat,
// Q8.24 saturating arithmetic, node states held in a rotating ring of cells.
//
//   channel | signals                               | direction
//   cfg     | cfg_we, cfg_index, cfg_data           | in, write only
//   in      | in_valid, in_ready, drive_y           | in
//   out     | out_valid, out_ready, node_index,     | out, one beat per node
//           | pos_x, pos_y, last                    |
//
// For a node with a spring to its right the 32-step root and two 32-step
// divides dominate; a spring no longer than the length floor skips the
// divides, and the driven node skips the spring work. A beat ends with a
// realign of the ring.
// Reset loads default registers and nodes at rest spacing along x.
// A stalled output holds the sequencer at the emit of the next node.
// ----------------------------------------------------------------------------
module mass_spring_chain_step_unit #(
	parameter int NODES     = msc_pkg::NODES_DEF,
	parameter int FRAC_BITS = msc_pkg::FRAC_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [msc_pkg::REG_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [31:0]          drive_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [3:0]                  node_index,
	output logic signed [31:0]          pos_x,
	output logic signed [31:0]          pos_y,
	output logic                        last
);
	import msc_pkg::*;

	localparam int CW = $clog2(NODES + 1);
	localparam logic [32:0] LEN_EPS = 33'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);

	typedef enum logic [4:0] {
		S_IDLE, S_NODE, S_DIFF, S_SQX, S_SQY, S_SQS, S_SQW, S_TEN, S_TENW,
		S_DVX, S_DVXS, S_DVXW, S_DVYS, S_DVYW, S_APPLY, S_DAMPX, S_DAMPY,
		S_DAMPW, S_PIN, S_PINW, S_ACCX, S_ACCY, S_VX, S_VY, S_PX, S_PY,
		S_PYW, S_EMIT, S_REAL
	} state_t;

	logic [30:0] k_q, c_q, im_q, w_q, rest_q;
	logic [24:0] dt_q;
	logic [4:0]  nu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= RST_STIFF;
			c_q    <= RST_DAMP;
			im_q   <= RST_INVM;
			w_q    <= RST_WEIGHT;
			dt_q   <= RST_DT;
			rest_q <= RST_REST;
			nu_q   <= RST_NODES;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_STIFF:  k_q    <= cfg_data;
				REG_DAMP:   c_q    <= cfg_data;
				REG_INVM:   im_q   <= cfg_data;
				REG_WEIGHT: w_q    <= cfg_data;
				REG_DT:     dt_q   <= cfg_data[24:0];
				REG_REST:   rest_q <= cfg_data;
				REG_NODES:  nu_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	logic [CW-1:0] n_eff;
	always_comb begin
		if (nu_q < 5'd3)
			n_eff = CW'(3);
		else if (int'(nu_q) > NODES)
			n_eff = CW'(NODES);
		else
			n_eff = CW'(nu_q);
	end

	state_t             state_q;
	logic [CW-1:0]      i_q;
	logic signed [31:0] drive_q;
	node_t              wk_q;
	logic [31:0]        mx_q, my_q;
	logic               dxneg_q, dyneg_q, half_q;
	logic [63:0]        acc_q;
	logic [32:0]        len_q;
	logic signed [31:0] ten_q, sx_q, sy_q, ax_q, ay_q;
	logic               sgn_q;
	logic               out_valid_q, last_q;
	logic [3:0]         node_index_q;
	logic signed [31:0] pos_x_q, pos_y_q;

	logic [31:0]        mul_a, mul_b;
	logic               mul_neg;
	logic [63:0]        mul_q;
	logic               mul_neg_q;
	logic signed [31:0] qp;

	always_ff @(posedge clk) begin
		mul_q     <= mul_a * mul_b;
		mul_neg_q <= mul_neg;
	end

	assign qp = sat_mag(mul_q >> FRAC_BITS, mul_neg_q);

	node_t              cell_q [NODES];
	cell_ctl_t          cell_ctl [NODES];
	node_t              tail;
	logic signed [31:0] f1x_n, f1y_n;
	logic               emit_ok, ring_shift, last_node;

	assign last_node  = (i_q == n_eff - CW'(1));
	assign emit_ok    = !out_valid_q || out_ready;
	assign ring_shift = (state_q == S_EMIT && emit_ok) ||
	                    (state_q == S_REAL && i_q != CW'(NODES));

	always_comb begin
		if (state_q == S_REAL) begin
			tail = cell_q[0];
		end else begin
			tail    = wk_q;
			tail.fx = '0;
			tail.fy = '0;
		end
	end

	assign f1x_n = sat34({{2{cell_q[1].fx[31]}}, cell_q[1].fx} - {{2{sx_q[31]}}, sx_q});
	assign f1y_n = sat34({{2{cell_q[1].fy[31]}}, cell_q[1].fy} - {{2{sy_q[31]}}, sy_q});

	for (genvar j = 0; j < NODES; j++) begin : g_cell
		localparam logic signed [31:0] PXR = rst_pos_x(j);
		assign cell_ctl[j].shift = ring_shift;
		assign cell_ctl[j].f_we  = (state_q == S_APPLY) && (j == 1);
		if (j == NODES - 1) begin : g_tail
			msc_cell #(.PX_RST(PXR)) u_cell (
				.clk, .arst_n, .ctl(cell_ctl[j]), .d_in(tail),
				.fx_in(f1x_n), .fy_in(f1y_n), .q(cell_q[j])
			);
		end else begin : g_body
			msc_cell #(.PX_RST(PXR)) u_cell (
				.clk, .arst_n, .ctl(cell_ctl[j]), .d_in(cell_q[j+1]),
				.fx_in(f1x_n), .fy_in(f1y_n), .q(cell_q[j])
			);
		end
	end

	logic signed [32:0] dx_c, dy_c;
	logic [31:0]        mx_c, my_c, mxh, myh;
	logic signed [33:0] d_w;
	logic signed [31:0] d_c;

	assign dx_c = {cell_q[1].px[31], cell_q[1].px} - {wk_q.px[31], wk_q.px};
	assign dy_c = {cell_q[1].py[31], cell_q[1].py} - {wk_q.py[31], wk_q.py};
	assign mx_c = mag32(dx_c);
	assign my_c = mag32(dy_c);
	assign mxh  = half_q ? (mx_q >> 1) : mx_q;
	assign myh  = half_q ? (my_q >> 1) : my_q;
	assign d_w  = $signed({1'b0, len_q}) - $signed({3'b000, rest_q});
	assign d_c  = sat34(d_w);

	logic        sq_start, dv_start;
	unit_stat_t  sq_stat, dv_stat;
	logic [31:0] sq_root;
	logic [63:0] dv_quo;

	assign sq_start = (state_q == S_SQS);
	assign dv_start = (state_q == S_DVXS) || (state_q == S_DVYS);

	msc_sqrt u_sqrt (
		.clk, .arst_n, .start(sq_start), .rad(62'(acc_q + mul_q) == 0 ? 63'd0 : 63'(acc_q + mul_q)),
		.stat(sq_stat), .root(sq_root)
	);

	msc_div u_div (
		.clk, .arst_n, .start(dv_start), .dividend(mul_q), .divisor(len_q),
		.stat(dv_stat), .quo(dv_quo)
	);

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (state_q)
			S_SQX: begin
				mul_a = mxh;
				mul_b = mxh;
			end
			S_SQY: begin
				mul_a = myh;
				mul_b = myh;
			end
			S_TEN: begin
				mul_a   = {1'b0, k_q};
				mul_b   = mag32({d_c[31], d_c});
				mul_neg = d_c[31];
			end
			S_DVX: begin
				mul_a   = mag32({ten_q[31], ten_q});
				mul_b   = mx_q;
				mul_neg = ten_q[31] ^ dxneg_q;
			end
			S_DVXW: begin
				mul_a   = mag32({ten_q[31], ten_q});
				mul_b   = my_q;
				mul_neg = ten_q[31] ^ dyneg_q;
			end
			S_DAMPX: begin
				mul_a   = {1'b0, c_q};
				mul_b   = mag32({wk_q.vx[31], wk_q.vx});
				mul_neg = wk_q.vx[31];
			end
			S_DAMPY: begin
				mul_a   = {1'b0, c_q};
				mul_b   = mag32({wk_q.vy[31], wk_q.vy});
				mul_neg = wk_q.vy[31];
			end
			S_PIN: begin
				mul_a = {1'b0, rest_q};
				mul_b = 32'(n_eff - CW'(1));
			end
			S_ACCX: begin
				mul_a   = mag32({wk_q.fx[31], wk_q.fx});
				mul_b   = {1'b0, im_q};
				mul_neg = wk_q.fx[31];
			end
			S_ACCY: begin
				mul_a   = mag32({wk_q.fy[31], wk_q.fy});
				mul_b   = {1'b0, im_q};
				mul_neg = wk_q.fy[31];
			end
			S_VX: begin
				mul_a   = {7'd0, dt_q};
				mul_b   = mag32({ax_q[31], ax_q});
				mul_neg = ax_q[31];
			end
			S_VY: begin
				mul_a   = {7'd0, dt_q};
				mul_b   = mag32({ay_q[31], ay_q});
				mul_neg = ay_q[31];
			end
			S_PX: begin
				mul_a   = {7'd0, dt_q};
				mul_b   = mag32({wk_q.vx[31], wk_q.vx});
				mul_neg = wk_q.vx[31];
			end
			S_PY: begin
				mul_a   = {7'd0, dt_q};
				mul_b   = mag32({wk_q.vy[31], wk_q.vy});
				mul_neg = wk_q.vy[31];
			end
			default: ;
		endcase
	end

	logic signed [31:0] fy_t;
	assign fy_t = sat34({{2{wk_q.fy[31]}}, wk_q.fy} - {{2{qp[31]}}, qp});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			i_q          <= '0;
			drive_q      <= '0;
			wk_q         <= '0;
			mx_q         <= '0;
			my_q         <= '0;
			dxneg_q      <= 1'b0;
			dyneg_q      <= 1'b0;
			half_q       <= 1'b0;
			acc_q        <= '0;
			len_q        <= '0;
			ten_q        <= '0;
			sx_q         <= '0;
			sy_q         <= '0;
			ax_q         <= '0;
			ay_q         <= '0;
			sgn_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			last_q       <= 1'b0;
			node_index_q <= '0;
			pos_x_q      <= '0;
			pos_y_q      <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						drive_q <= drive_y;
						i_q     <= '0;
						state_q <= S_NODE;
					end
				end
				S_NODE: begin
					if (i_q == n_eff) begin
						state_q <= S_REAL;
					end else begin
						wk_q    <= cell_q[0];
						state_q <= last_node ? S_DAMPX : S_DIFF;
					end
				end
				S_DIFF: begin
					mx_q    <= mx_c;
					my_q    <= my_c;
					dxneg_q <= dx_c[32];
					dyneg_q <= dy_c[32];
					half_q  <= mx_c[31] | my_c[31];
					state_q <= S_SQX;
				end
				S_SQX: state_q <= S_SQY;
				S_SQY: begin
					acc_q   <= mul_q;
					state_q <= S_SQS;
				end
				S_SQS: state_q <= S_SQW;
				S_SQW: begin
					if (sq_stat.done) begin
						len_q   <= half_q ? {sq_root, 1'b0} : {1'b0, sq_root};
						state_q <= S_TEN;
					end
				end
				S_TEN: begin
					if (len_q <= LEN_EPS) begin
						sx_q    <= '0;
						sy_q    <= '0;
						state_q <= S_APPLY;
					end else begin
						state_q <= S_TENW;
					end
				end
				S_TENW: begin
					ten_q   <= qp;
					state_q <= S_DVX;
				end
				S_DVX: state_q <= S_DVXS;
				S_DVXS: begin
					sgn_q   <= mul_neg_q;
					state_q <= S_DVXW;
				end
				S_DVXW: begin
					if (dv_stat.done) begin
						sx_q    <= sat_mag(dv_quo, sgn_q);
						state_q <= S_DVYS;
					end
				end
				S_DVYS: begin
					sgn_q   <= mul_neg_q;
					state_q <= S_DVYW;
				end
				S_DVYW: begin
					if (dv_stat.done) begin
						sy_q    <= sat_mag(dv_quo, sgn_q);
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					wk_q.fx <= sat34({{2{wk_q.fx[31]}}, wk_q.fx} + {{2{sx_q[31]}}, sx_q});
					wk_q.fy <= sat34({{2{wk_q.fy[31]}}, wk_q.fy} + {{2{sy_q[31]}}, sy_q});
					state_q <= S_DAMPX;
				end
				S_DAMPX: state_q <= S_DAMPY;
				S_DAMPY: begin
					wk_q.fx <= sat34({{2{wk_q.fx[31]}}, wk_q.fx} - {{2{qp[31]}}, qp});
					state_q <= S_DAMPW;
				end
				S_DAMPW: begin
					wk_q.fy <= sat34({{2{fy_t[31]}}, fy_t} - {3'b000, w_q});
					state_q <= S_PIN;
				end
				S_PIN: begin
					if (i_q == '0) begin
						wk_q    <= '0;
						state_q <= S_EMIT;
					end else if (last_node) begin
						wk_q.py <= drive_q;
						wk_q.vx <= '0;
						wk_q.vy <= '0;
						state_q <= S_PINW;
					end else begin
						state_q <= S_ACCX;
					end
				end
				S_PINW: begin
					wk_q.px <= sat_mag(mul_q, 1'b0);
					state_q <= S_ACCX;
				end
				S_ACCX: state_q <= S_ACCY;
				S_ACCY: begin
					ax_q    <= qp;
					state_q <= S_VX;
				end
				S_VX: begin
					ay_q    <= qp;
					state_q <= S_VY;
				end
				S_VY: begin
					wk_q.vx <= sat34({{2{wk_q.vx[31]}}, wk_q.vx} + {{2{qp[31]}}, qp});
					state_q <= S_PX;
				end
				S_PX: begin
					wk_q.vy <= sat34({{2{wk_q.vy[31]}}, wk_q.vy} + {{2{qp[31]}}, qp});
					state_q <= S_PY;
				end
				S_PY: begin
					wk_q.px <= sat34({{2{wk_q.px[31]}}, wk_q.px} + {{2{qp[31]}}, qp});
					state_q <= S_PYW;
				end
				S_PYW: begin
					wk_q.py <= sat34({{2{wk_q.py[31]}}, wk_q.py} + {{2{qp[31]}}, qp});
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_ok) begin
						out_valid_q  <= 1'b1;
						node_index_q <= 4'(i_q);
						pos_x_q      <= wk_q.px;
						pos_y_q      <= wk_q.py;
						last_q       <= last_node;
						i_q          <= i_q + CW'(1);
						state_q      <= S_NODE;
					end
				end
				S_REAL: begin
					if (i_q == CW'(NODES))
						state_q <= S_IDLE;
					else
						i_q <= i_q + CW'(1);
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign node_index = node_index_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |-> !sq_stat.busy)
		else $error("root started while busy");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> !dv_stat.busy)
		else $error("divide started while busy");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_ok) |-> (i_q < n_eff))
		else $error("beat emitted past the active nodes");

	a_ring_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ring_shift)
		else $error("ring moved while idle");
`endif

endmodule
